### sv/knps_pkg.sv
// Shared widths and configuration register indexes for the k-nearest select block.
`default_nettype none
package knps_pkg;

    localparam int ID_W    = 32;
    localparam int POS_W   = 24;
    localparam int DIST_W  = 52;
    localparam int SQ_W    = 2 * POS_W;
    localparam int K_W     = 7;
    localparam int RANK_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int RESULT_CAP = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_K_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Z = 2'd3;

endpackage
`default_nettype wire

### sv/knps_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module knps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### sv/knps_dist.sv
// Squared distance unit: one shared squarer stepped over the three axes.
`default_nettype none
module knps_dist
    import knps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [POS_W-1:0]  i_pos_x,
    input  wire logic [POS_W-1:0]  i_pos_y,
    input  wire logic [POS_W-1:0]  i_pos_z,
    input  wire logic [POS_W-1:0]  i_query_x,
    input  wire logic [POS_W-1:0]  i_query_y,
    input  wire logic [POS_W-1:0]  i_query_z,
    output logic                   o_done,
    output logic [DIST_W-1:0]      o_dist
);

    logic              r_busy;
    logic [1:0]        r_step;
    logic [POS_W-1:0]  r_ax [3];
    logic [SQ_W-1:0]   r_prod;
    logic [DIST_W-1:0] r_acc;
    logic [POS_W-1:0]  ax_sel;
    logic [POS_W-1:0]  abs_x, abs_y, abs_z;

    function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        logic [POS_W:0] d;
        logic [POS_W:0] m;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        m = d[POS_W] ? (~d + 1'b1) : d;
        return m[POS_W-1:0];
    endfunction

    assign abs_x = abs_diff(i_pos_x, i_query_x);
    assign abs_y = abs_diff(i_pos_y, i_query_y);
    assign abs_z = abs_diff(i_pos_z, i_query_z);

    always_comb begin
        case (r_step)
            2'd0:    ax_sel = r_ax[0];
            2'd1:    ax_sel = r_ax[1];
            default: ax_sel = r_ax[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= 2'd0;
        end else if (r_busy) begin
            r_step <= r_step + 2'd1;
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Square one axis per cycle; accumulate the previous product behind it.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ax[0] <= abs_x;
            r_ax[1] <= abs_y;
            r_ax[2] <= abs_z;
        end
        if (r_busy) begin
            r_prod <= ax_sel * ax_sel;
            case (r_step)
                2'd0:    r_acc <= '0;
                2'd1:    r_acc <= DIST_W'(r_prod);
                2'd2:    r_acc <= r_acc + DIST_W'(r_prod);
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_done = r_busy && (r_step == 2'd3);
    assign o_dist = r_acc + DIST_W'(r_prod);

endmodule
`default_nettype wire

### sv/k_nearest_position_select_unit.sv
// Top level: entry store, distance unit and the k-nearest selection sequencer.
// Load: an entry is accepted in IDLE and written when the distance unit is done (DIST).
// Selection: after the last load, a setup state (START), then per result one scan of the
// store (SCAN, one RAM read port) and a hand-out (EMIT) that waits for a free output.
// Input not ready from acceptance until the write; after a last load, until the run ends.
// Reset (synchronous, active low) empties the store and sets k_count = 1, query = 0.
`default_nettype none
module k_nearest_position_select_unit
    import knps_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]  i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [ID_W-1:0]       i_entry_id,
    input  wire logic [POS_W-1:0]      i_pos_x,
    input  wire logic [POS_W-1:0]      i_pos_y,
    input  wire logic [POS_W-1:0]      i_pos_z,
    input  wire logic                  i_load_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [ID_W-1:0]            o_near_id,
    output logic [DIST_W-1:0]          o_dist_sq,
    output logic [RANK_W-1:0]          o_rank,
    output logic                       o_out_last
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int MW = (CW > K_W) ? CW : K_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIST  = 5'b00010,
        S_START = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state            r_state;
    logic [K_W-1:0]    r_k;
    logic [POS_W-1:0]  r_qx, r_qy, r_qz;
    logic              r_last;
    logic [ID_W-1:0]   r_id_hold;
    logic [CW-1:0]     r_count;
    logic [K_W-1:0]    r_n;
    logic [K_W-1:0]    r_rank;
    logic [CW-1:0]     r_addr;
    logic              r_pend;
    logic [AW-1:0]     r_pend_idx;
    logic              r_found;
    logic [DIST_W-1:0] r_best_d;
    logic [AW-1:0]     r_best_i;
    logic [ID_W-1:0]   r_best_id;
    logic              r_have_last;
    logic [DIST_W-1:0] r_last_d;
    logic [AW-1:0]     r_last_i;
    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;
    logic [DIST_W-1:0] r_out_d;
    logic [RANK_W-1:0] r_out_rank;
    logic              r_out_last;

    logic              in_acc;
    logic              dist_done;
    logic [DIST_W-1:0] dist_val;
    logic              wr_en;
    logic [DIST_W-1:0] rd_dist;
    logic [ID_W-1:0]   rd_id;
    logic [MW-1:0]     cnt_w, k_w, min_w;
    logic [K_W-1:0]    n_calc;
    logic              cand, take;
    logic              out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= K_W'(1);
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_K_COUNT: r_k  <= i_cfg_data[K_W-1:0];
                CFG_QUERY_X: r_qx <= i_cfg_data[POS_W-1:0];
                CFG_QUERY_Y: r_qy <= i_cfg_data[POS_W-1:0];
                CFG_QUERY_Z: r_qz <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    knps_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_pos_z   (i_pos_z),
        .i_query_x (r_qx),
        .i_query_y (r_qy),
        .i_query_z (r_qz),
        .o_done    (dist_done),
        .o_dist    (dist_val)
    );

    // Drop the load once the store is full.
    assign wr_en = (r_state == S_DIST) && dist_done && (r_count < CW'(MAX_ENTRIES));

    knps_ram #(.WIDTH(DIST_W), .DEPTH(MAX_ENTRIES)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (dist_val),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd_dist)
    );

    knps_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_id_hold),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rd_id)
    );

    // Result count: min(k, stored entries, cap).
    always_comb begin
        cnt_w = MW'(r_count);
        k_w   = MW'(r_k);
        min_w = (k_w < cnt_w) ? k_w : cnt_w;
        if (min_w > MW'(RESULT_CAP)) begin
            n_calc = K_W'(RESULT_CAP);
        end else begin
            n_calc = min_w[K_W-1:0];
        end
    end

    // Candidate must rank strictly after the last reported (distance, index) pair.
    assign cand = !r_have_last || (rd_dist > r_last_d)
               || ((rd_dist == r_last_d) && (r_pend_idx > r_last_i));
    assign take = r_pend && cand && (!r_found || (rd_dist < r_best_d));

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_have_last <= 1'b0;
            r_out_valid <= 1'b0;
            r_rank      <= '0;
            r_addr      <= '0;
        end else begin
            // EMIT reloads the output register itself.
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    if (dist_done) begin
                        if (wr_en) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= r_last ? S_START : S_IDLE;
                    end
                end
                S_START: begin
                    r_rank      <= '0;
                    r_have_last <= 1'b0;
                    r_addr      <= '0;
                    r_found     <= 1'b0;
                    r_pend      <= 1'b0;
                    if (n_calc == '0) begin
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_pend <= (r_addr < r_count);
                    if (r_addr < r_count) begin
                        r_addr <= r_addr + CW'(1);
                    end
                    if (take) begin
                        r_found <= 1'b1;
                    end
                    if (!r_pend && (r_addr == r_count)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_have_last <= 1'b1;
                        r_rank      <= r_rank + K_W'(1);
                        r_addr      <= '0;
                        r_found     <= 1'b0;
                        r_pend      <= 1'b0;
                        if (r_rank + K_W'(1) == r_n) begin
                            r_count <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_last    <= i_load_last;
            r_id_hold <= i_entry_id;
        end
        if (r_state == S_START) begin
            r_n <= n_calc;
        end
        r_pend_idx <= r_addr[AW-1:0];
        if ((r_state == S_SCAN) && take) begin
            r_best_d  <= rd_dist;
            r_best_i  <= r_pend_idx;
            r_best_id <= rd_id;
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_last_d   <= r_best_d;
            r_last_i   <= r_best_i;
            r_out_id   <= r_best_id;
            r_out_d    <= r_best_d;
            r_out_rank <= r_rank[RANK_W-1:0];
            r_out_last <= (r_rank + K_W'(1) == r_n);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_near_id   = r_out_id;
    assign o_dist_sq   = r_out_d;
    assign o_rank      = r_out_rank;
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire

### test/k_nearest_position_select_unit_tb.sv
// Testbench for the k-nearest position select unit: directed table, random sets, self-check.
module k_nearest_position_select_unit_tb;
    import knps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ENT        = 64;
    localparam int RANDOM_ITEMS   = 120;
    localparam int SETTLE_CYCLES  = 100;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [DIST_W-1:0] DIST_MAX = 52'h2FFFFFA000003;

    typedef enum logic {ROW_LOAD, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic                    last;
    } t_entry;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dsq;
        logic [RANK_W-1:0] rank;
        logic              last;
    } t_near;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DAT_W-1:0]    data;
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic                    last;
        logic                    pin;
        logic [DIST_W-1:0]       pin_dist;
    } t_row;

    // Rows with pin set carry their single result typed in.
    localparam t_row PLAN [29] = '{
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'hDEADBEEF, 24'h1, 24'h2, 24'h3, 1'b1, 1'b1, 52'd14},
        '{ROW_CFG, CFG_QUERY_X, 24'h7FFFFF, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_CFG, CFG_QUERY_Y, 24'h7FFFFF, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_CFG, CFG_QUERY_Z, 24'h7FFFFF, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'hFFFFFFFF, 24'h800000, 24'h800000, 24'h800000,
          1'b1, 1'b1, DIST_MAX},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'h00000000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
          1'b1, 1'b1, 52'd0},
        '{ROW_CFG, CFG_QUERY_X, 24'h800000, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_CFG, CFG_QUERY_Y, 24'h800000, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_CFG, CFG_QUERY_Z, 24'h800000, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'h5A5A5A5A, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
          1'b1, 1'b1, DIST_MAX},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'hA5A5A5A5, 24'h800000, 24'h800000, 24'h800000,
          1'b1, 1'b1, 52'd0},
        '{ROW_CFG, CFG_K_COUNT, 24'd64, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_CFG, CFG_QUERY_X, 24'h0, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_CFG, CFG_QUERY_Y, 24'h0, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_CFG, CFG_QUERY_Z, 24'h0, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        // equal distances: earlier load wins; k above the stored count reports all
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd10, 24'h1, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd11, 24'h0, 24'hFFFFFF, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd12, 24'h0, 24'h0, 24'h1, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd13, 24'h0, 24'h0, 24'h0, 1'b1, 1'b0, 52'd0},
        // query moves between two loads of one set
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd20, 24'h5, 24'h5, 24'h5, 1'b0, 1'b0, 52'd0},
        '{ROW_CFG, CFG_QUERY_X, 24'h5, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd21, 24'h5, 24'h5, 24'h5, 1'b1, 1'b0, 52'd0},
        // zero k: nothing comes out, the store still empties
        '{ROW_CFG, CFG_K_COUNT, 24'd0, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd30, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd31, 24'h2, 24'h2, 24'h2, 1'b1, 1'b0, 52'd0},
        '{ROW_CFG, CFG_K_COUNT, 24'd2, 32'h0, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd40, 24'h3, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd41, 24'h0, 24'h0, 24'h0, 1'b0, 1'b0, 52'd0},
        '{ROW_LOAD, CFG_K_COUNT, 24'h0, 32'd42, 24'h3, 24'h0, 24'h0, 1'b1, 1'b0, 52'd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [ID_W-1:0]       i_entry_id = '0;
    logic [POS_W-1:0]      i_pos_x = '0;
    logic [POS_W-1:0]      i_pos_y = '0;
    logic [POS_W-1:0]      i_pos_z = '0;
    logic                  i_load_last = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [ID_W-1:0]       o_near_id;
    logic [DIST_W-1:0]     o_dist_sq;
    logic [RANK_W-1:0]     o_rank;
    logic                  o_out_last;

    // shadow registers and entry store of the block
    logic [K_W-1:0]          sel_k = 7'd1;
    logic signed [POS_W-1:0] qry_x = '0;
    logic signed [POS_W-1:0] qry_y = '0;
    logic signed [POS_W-1:0] qry_z = '0;
    logic [ID_W-1:0]         loaded_ids [MAX_ENT];
    logic [DIST_W-1:0]       loaded_dists [MAX_ENT];
    bit                      taken [MAX_ENT];
    int                      loaded_count = 0;
    t_near                   nearest_q [$];

    logic                    pin_on = 1'b0;
    logic [DIST_W-1:0]       pin_dist = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int random_items = 0;
    int fail_count = 0;
    int loads_seen = 0;
    int runs_seen = 0;
    int results_seen = 0;
    int writes_seen = 0;
    int quiet_cycles = 0;

    k_nearest_position_select_unit #(
        .MAX_ENTRIES(MAX_ENT)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_entry_id(i_entry_id),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z),
        .i_load_last(i_load_last),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_near_id(o_near_id),
        .o_dist_sq(o_dist_sq),
        .o_rank(o_rank),
        .o_out_last(o_out_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DIST_W-1:0] query_dist(logic signed [POS_W-1:0] px,
                                                     logic signed [POS_W-1:0] py,
                                                     logic signed [POS_W-1:0] pz);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(px) - longint'(qry_x);
        dy = longint'(py) - longint'(qry_y);
        dz = longint'(pz) - longint'(qry_z);
        return DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Pick the nearest untaken entry min(k, stored count, cap) times; strict less keeps the earlier entry on a tie.
    function automatic void rank_nearest();
        int    n;
        int    best;
        bit    found;
        t_near r;
        n = int'(sel_k);
        if (n > loaded_count) n = loaded_count;
        if (n > RESULT_CAP) n = RESULT_CAP;
        for (int i = 0; i < MAX_ENT; i++) taken[i] = 1'b0;
        for (int rk = 0; rk < n; rk++) begin
            found = 1'b0;
            best = 0;
            for (int i = 0; i < loaded_count; i++) begin
                if (!taken[i] && (!found || loaded_dists[i] < loaded_dists[best])) begin
                    best = i;
                    found = 1'b1;
                end
            end
            taken[best] = 1'b1;
            r.id = loaded_ids[best];
            r.dsq = loaded_dists[best];
            r.rank = RANK_W'(rk);
            r.last = (rk == n - 1);
            nearest_q.push_back(r);
        end
        loaded_count = 0;
    endfunction

    function automatic void load_entry(t_entry e);
        t_near r;
        int    base;
        if (loaded_count < MAX_ENT) begin
            loaded_ids[loaded_count] = e.id;
            loaded_dists[loaded_count] = query_dist(e.x, e.y, e.z);
            loaded_count++;
        end
        if (!e.last) return;
        runs_seen++;
        if (pin_on) begin
            // keep results of earlier runs still waiting; swap in the typed-in one
            base = nearest_q.size();
            rank_nearest();
            while (nearest_q.size() > base) void'(nearest_q.pop_back());
            r.id = e.id;
            r.dsq = pin_dist;
            r.rank = '0;
            r.last = 1'b1;
            nearest_q.push_back(r);
        end else begin
            rank_nearest();
        end
    endfunction

    // Observe all three channels at the rising edge.
    always @(posedge i_clk) begin
        t_entry e;
        t_near  want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                writes_seen++;
                case (i_cfg_index)
                    CFG_K_COUNT: sel_k = i_cfg_data[K_W-1:0];
                    CFG_QUERY_X: qry_x = i_cfg_data;
                    CFG_QUERY_Y: qry_y = i_cfg_data;
                    CFG_QUERY_Z: qry_z = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                loads_seen++;
                e.id = i_entry_id;
                e.x = i_pos_x;
                e.y = i_pos_y;
                e.z = i_pos_z;
                e.last = i_load_last;
                load_entry(e);
            end
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (nearest_q.size() == 0) begin
                    $error("unexpected result transaction: near_id %h rank %0d",
                           o_near_id, o_rank);
                    fail_count++;
                end else begin
                    want = nearest_q.pop_front();
                    if (o_near_id !== want.id) begin
                        $error("near_id expected %h got %h", want.id, o_near_id);
                        fail_count++;
                    end
                    if (o_dist_sq !== want.dsq) begin
                        $error("dist_sq expected %h got %h", want.dsq, o_dist_sq);
                        fail_count++;
                    end
                    if (o_rank !== want.rank) begin
                        $error("rank expected %0d got %0d", want.rank, o_rank);
                        fail_count++;
                    end
                    if (o_out_last !== want.last) begin
                        $error("out_last expected %b got %b", want.last, o_out_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready)
            || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Write a register once the block has drained and gone quiet.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_in_valid = 1'b0;
        while (nearest_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_entry(input t_entry e);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_entry_id = e.id;
        i_pos_x = e.x;
        i_pos_y = e.y;
        i_pos_z = e.z;
        i_load_last = e.last;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic random_query();
        logic [CFG_DAT_W-1:0] v;
        if ($urandom_range(1)) v = CFG_DAT_W'($urandom);
        else v = CFG_DAT_W'(int'($urandom_range(64)) - 32);
        case ($urandom_range(2))
            0: write_reg(CFG_QUERY_X, v);
            1: write_reg(CFG_QUERY_Y, v);
            default: write_reg(CFG_QUERY_Z, v);
        endcase
    endtask

    // Mix of far points, points close to the query and repeats, to provoke ties.
    task automatic send_set(input int size);
        t_entry e;
        t_entry prev;
        int     pick;
        prev = '0;
        for (int j = 0; j < size; j++) begin
            if (j > 0 && $urandom_range(99) < 4) random_query();
            pick = $urandom_range(99);
            e.id = $urandom;
            if (pick < 30) begin
                e.x = POS_W'($urandom);
                e.y = POS_W'($urandom);
                e.z = POS_W'($urandom);
            end else if (pick < 80) begin
                e.x = qry_x + POS_W'(int'($urandom_range(6)) - 3);
                e.y = qry_y + POS_W'(int'($urandom_range(6)) - 3);
                e.z = qry_z + POS_W'(int'($urandom_range(6)) - 3);
            end else begin
                e.x = prev.x;
                e.y = prev.y;
                e.z = prev.z;
            end
            e.last = (j == size - 1);
            send_entry(e);
            random_items++;
            prev = e;
        end
    endtask

    task automatic retune();
        if ($urandom_range(99) < 40) begin
            case ($urandom_range(3))
                0: write_reg(CFG_K_COUNT, CFG_DAT_W'(0));
                1: write_reg(CFG_K_COUNT, CFG_DAT_W'(64));
                default: write_reg(CFG_K_COUNT, CFG_DAT_W'($urandom_range(1, 8)));
            endcase
        end
        if ($urandom_range(99) < 30) random_query();
    endtask

    initial begin
        t_entry e;
        int     size;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_pct = 29;
        stall_pct = 53;
        foreach (PLAN[r]) begin
            if (PLAN[r].kind == ROW_CFG) begin
                write_reg(PLAN[r].idx, PLAN[r].data);
            end else begin
                pin_on = PLAN[r].pin;
                pin_dist = PLAN[r].pin_dist;
                e.id = PLAN[r].id;
                e.x = PLAN[r].x;
                e.y = PLAN[r].y;
                e.z = PLAN[r].z;
                e.last = PLAN[r].last;
                send_entry(e);
                pin_on = 1'b0;
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 29 : (ph == 1) ? 53 : 0;
            stall_pct = (ph == 0) ? 53 : (ph == 1) ? 29 : 0;
            if (ph == 2) begin
                // overfill the store with the largest k
                write_reg(CFG_K_COUNT, CFG_DAT_W'(64));
                send_set(MAX_ENT + 4);
            end
            while (random_items < (ph + 1) * RANDOM_ITEMS / 3) begin
                retune();
                size = ($urandom_range(99) < 6) ? $urandom_range(40, 70) : $urandom_range(1, 6);
                send_set(size);
            end
        end

        i_in_valid = 1'b0;
        while (nearest_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d loads in %0d selection runs, %0d results, %0d register writes",
                 loads_seen, runs_seen, results_seen, writes_seen);
        $display("Mismatches: %0d", fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/knps_pkg.sv
sv/knps_ram.sv
sv/knps_dist.sv
sv/k_nearest_position_select_unit.sv
test/k_nearest_position_select_unit_tb.sv
